// ===== src/olie_pkg.sv =====
// Types and codes shared by the ordered list insert engine.
package olie_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned LEN_W   = 5;

  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_BACK  = 2'd1,
    REQ_INSERT_KEY = 2'd2,
    REQ_POP_FRONT  = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    req_type_e                  req_type;
    logic signed [VALUE_W-1:0]  value;
    logic signed [VALUE_W-1:0]  key;
  } req_t;

  typedef struct packed {
    status_e                    status;
    logic signed [VALUE_W-1:0]  popped_value;
    logic [LEN_W-1:0]           length;
  } rsp_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic      cmp_en;
    logic      apply_en;
    req_type_e req_type;
  } cell_ctrl_t;

  // Where a cell sits relative to the current fill level.
  typedef struct packed {
    logic in_use;
    logic is_head;
    logic is_tail;
  } cell_pos_t;

endpackage

// ===== src/olie_cell.sv =====
// One list slot: holds an entry, compares it with the key, moves data to its neighbors.
module olie_cell import olie_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  cell_ctrl_t            ctrl_i,
  input  cell_pos_t             pos_i,
  input  logic [DATA_WIDTH-1:0] new_data_i,
  input  logic [DATA_WIDTH-1:0] key_i,
  input  logic [DATA_WIDTH-1:0] left_data_i,
  input  logic [DATA_WIDTH-1:0] right_data_i,
  input  logic                  hit_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  hit_o
);

  typedef enum logic [1:0] {
    OP_HOLD       = 2'd0,
    OP_LOAD       = 2'd1,
    OP_FROM_LEFT  = 2'd2,
    OP_FROM_RIGHT = 2'd3
  } cell_op_e;

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  match_q;
  cell_op_e              op;

  always_comb begin
    unique case (ctrl_i.req_type)
      REQ_PUSH_FRONT: op = pos_i.is_head ? OP_LOAD : OP_FROM_LEFT;
      REQ_PUSH_BACK:  op = pos_i.is_tail ? OP_LOAD : OP_HOLD;
      REQ_INSERT_KEY: begin
        // Cells past the first match shift back; the first match (or tail) takes the value.
        if (hit_i) begin
          op = OP_FROM_LEFT;
        end else if (match_q || pos_i.is_tail) begin
          op = OP_LOAD;
        end else begin
          op = OP_HOLD;
        end
      end
      REQ_POP_FRONT:  op = OP_FROM_RIGHT;
      default:        op = OP_HOLD;
    endcase
  end

  always_comb begin
    unique case (op)
      OP_LOAD:       data_d = new_data_i;
      OP_FROM_LEFT:  data_d = left_data_i;
      OP_FROM_RIGHT: data_d = right_data_i;
      default:       data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmp_en) begin
      match_q <= pos_i.in_use && (data_q == key_i);
    end
    if (ctrl_i.apply_en) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;
  assign hit_o  = hit_i | match_q;

endmodule

// ===== src/ordered_list_insert_engine_top.sv =====
// Top level of the ordered list insert engine: sequencer, fill count and the cell chain.
//
// Usage: requests arrive on the in channel (in_valid_i / in_ready_o, payload req_i)
// and each yields exactly one response beat on the out channel (out_valid_o /
// out_ready_i, payload rsp_o): status, popped front value and the new length.
// The list lives in a chain of CAPACITY cells; every cell compares its entry
// with the key at once, and the cells shift together toward the back (push
// front, or past the first match on insert) or toward the front (pop).
// One request is in work at a time: ST_IDLE takes it, ST_CMP runs the registered
// key compare in the cells, and ST_APPLY shifts the chain and loads the output
// register; a new request is taken only after the last one has left ST_APPLY.
// The output register lets the next request enter while a response waits; if
// the receiver stalls, the following request holds in its shift step until the
// waiting beat is taken.
// Reset clears the fill count and the handshake state, leaving an empty list;
// entries are not cleared and no clearing pass runs.
module ordered_list_insert_engine_top import olie_pkg::*; #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CMP   = 3'b010,
    ST_APPLY = 3'b100
  } state_e;

  state_e            state_q, state_d;
  req_t              req_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q, out_valid_d;
  rsp_t              rsp_q, rsp_d;

  logic                  in_fire, apply_fire;
  logic                  full, empty, is_pop, refused;
  logic [DATA_WIDTH-1:0] new_data, key_data;
  cell_ctrl_t            ctrl;

  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [CAPACITY:0]     hit;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign apply_fire = (state_q == ST_APPLY) && (!out_valid_q || out_ready_i);

  assign full    = (count_q == CNT_W'(CAPACITY));
  assign empty   = (count_q == '0);
  assign is_pop  = (req_q.req_type == REQ_POP_FRONT);
  assign refused = is_pop ? empty : full;

  assign new_data = DATA_WIDTH'(req_q.value);
  assign key_data = DATA_WIDTH'(req_q.key);

  assign ctrl.cmp_en   = (state_q == ST_CMP);
  assign ctrl.apply_en = apply_fire && !refused;
  assign ctrl.req_type = req_q.req_type;

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_pos_t             pos;
    logic [DATA_WIDTH-1:0] left_data, right_data;

    assign pos.in_use  = (CNT_W'(i) < count_q);
    assign pos.is_head = (i == 0);
    assign pos.is_tail = (CNT_W'(i) == count_q);

    if (i == 0) begin : g_first
      assign left_data = new_data;
    end else begin : g_inner_left
      assign left_data = cell_data[i-1];
    end

    // The last cell's vacated content on a pop lies beyond the fill level.
    if (i == CAPACITY - 1) begin : g_last
      assign right_data = cell_data[i];
    end else begin : g_inner_right
      assign right_data = cell_data[i+1];
    end

    olie_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .pos_i        (pos),
      .new_data_i   (new_data),
      .key_i        (key_data),
      .left_data_i  (left_data),
      .right_data_i (right_data),
      .hit_i        (hit[i]),
      .data_o       (cell_data[i]),
      .hit_o        (hit[i+1])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_fire) state_d = ST_CMP;
      ST_CMP:   state_d = ST_APPLY;
      ST_APPLY: if (apply_fire) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.apply_en) begin
      count_d = is_pop ? count_q - CNT_W'(1) : count_q + CNT_W'(1);
    end
  end

  always_comb begin
    rsp_d.status       = STATUS_OK;
    rsp_d.popped_value = '0;
    if (refused) begin
      rsp_d.status = is_pop ? STATUS_EMPTY : STATUS_FULL;
    end else if (is_pop) begin
      rsp_d.popped_value = VALUE_W'(cell_data[0]);
    end
    rsp_d.length = LEN_W'(count_d);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (apply_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= req_i;
    end
    if (apply_fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ===== src/olie_checker.sv =====
// Port-level checks for the ordered list insert engine, bound to the top level.
module olie_checker import olie_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input rsp_t rsp_i
);

  // One request in work at a time: the input closes right after a beat.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after an accepted beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(rsp_i))
    else $error("stalled response beat dropped or changed");

  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (rsp_i.status == STATUS_EMPTY) |->
      (rsp_i.length == '0) && (rsp_i.popped_value == '0))
    else $error("refused pop reports a nonempty list or a value");

  a_full_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (rsp_i.status == STATUS_FULL) |->
      (rsp_i.length == LEN_W'(CAPACITY)) && (rsp_i.popped_value == '0))
    else $error("refused insert reports a length other than capacity");

endmodule

bind ordered_list_insert_engine_top olie_checker #(
  .CAPACITY (CAPACITY)
) u_olie_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .rsp_i       (rsp_o)
);

// ===== tb/sv/list_scoreboard_pkg.sv =====
// Scoreboard for the ordered list insert engine: list predictor and response check.
`timescale 1ns / 100ps
package list_scoreboard_pkg;
  import olie_pkg::*;

  localparam int unsigned LIST_DEPTH = 16;

  class list_scoreboard;
    logic signed [VALUE_W-1:0] shadow_list[$];
    rsp_t                      pending_rsp[$];
    int unsigned               mismatches;

    function new();
      mismatches = 0;
    endfunction

    function int unsigned pending_count();
      return pending_rsp.size();
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("[%0t] MISMATCH %s: got %0d expected %0d", $time, what, got, want);
      mismatches++;
    endtask

    // Apply one accepted request to the shadow list and queue its response.
    function void note_request(req_t req);
      rsp_t        rsp;
      int unsigned pos;
      rsp.status       = STATUS_OK;
      rsp.popped_value = '0;
      if (req.req_type == REQ_POP_FRONT) begin
        if (shadow_list.size() == 0) begin
          rsp.status = STATUS_EMPTY;
        end else begin
          rsp.popped_value = shadow_list.pop_front();
        end
      end else if (shadow_list.size() >= LIST_DEPTH) begin
        rsp.status = STATUS_FULL;
      end else begin
        case (req.req_type)
          REQ_PUSH_FRONT: shadow_list.push_front(req.value);
          REQ_PUSH_BACK:  shadow_list.push_back(req.value);
          default: begin
            // first match wins, head included; no match appends
            pos = shadow_list.size();
            for (int i = 0; i < shadow_list.size(); i++) begin
              if (shadow_list[i] == req.key) begin
                pos = i;
                break;
              end
            end
            shadow_list.insert(pos, req.value);
          end
        endcase
      end
      rsp.length = LEN_W'(shadow_list.size());
      pending_rsp.push_back(rsp);
    endfunction

    task check_response(rsp_t got);
      rsp_t want;
      if (pending_rsp.size() == 0) begin
        report_mismatch("response beat with nothing pending", got.length, 0);
        return;
      end
      want = pending_rsp.pop_front();
      if (got.status !== want.status)
        report_mismatch("status", got.status, want.status);
      if (got.popped_value !== want.popped_value)
        report_mismatch("popped_value", got.popped_value, want.popped_value);
      if (got.length !== want.length)
        report_mismatch("length", got.length, want.length);
    endtask
  endclass

endpackage

// ===== tb/sv/tb_top.sv =====
// Testbench top for the ordered list insert engine: stimulus, handshake and end of run.
`timescale 1ns / 100ps
module tb_top;
  import olie_pkg::*;
  import list_scoreboard_pkg::*;

  localparam int unsigned RANDOM_REQS = 450;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t req_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t rsp_o;

  list_scoreboard sb;
  int unsigned    reqs_taken;
  logic           sender_steady;

  ordered_list_insert_engine_top #(
    .CAPACITY  (LIST_DEPTH),
    .DATA_WIDTH(VALUE_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_i      (req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .rsp_o      (rsp_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Small pool so keys hit stored entries and duplicates show up often.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic signed [VALUE_W-1:0] pool[8];
    pool = '{32'sd0, 32'sd1, -32'sd1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd5, -32'sd5,
             32'sd100};
    if ($urandom_range(0, 3) != 0) return pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  task automatic send_req(req_type_e kind, logic signed [VALUE_W-1:0] value,
                          logic signed [VALUE_W-1:0] key);
    int unsigned gap;
    req_t        req;
    gap = sender_steady ? 0 : pick_gap();
    req.req_type = kind;
    req.value    = value;
    req.key      = key;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_i      <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_request(req_i);
        reqs_taken++;
      end
      if (out_valid_o && out_ready_i) sb.check_response(rsp_o);
    end
  end

  // Response side: random stalls, plus long holds so the block backs up.
  initial begin
    int unsigned hold_mark;
    hold_mark = 60;
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (reqs_taken >= hold_mark) begin
        hold_mark += 240;
        out_ready_i <= 1'b0;
        repeat (120) @(posedge clk_i);
      end else if ($urandom_range(0, 99) < 60) begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk_i);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int unsigned pop_pct;
    int unsigned r;
    req_type_e   kind;
    sb            = new();
    reqs_taken    = 0;
    sender_steady = 1'b0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    req_i      <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty pop, insert into empty, extremes, head / middle / missing key
    send_req(REQ_POP_FRONT, 32'sd77, 32'sd77);
    send_req(REQ_INSERT_KEY, 32'sd42, 32'sd42);
    send_req(REQ_POP_FRONT, 32'sd0, 32'sd0);
    send_req(REQ_PUSH_FRONT, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_req(REQ_PUSH_BACK, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_req(REQ_INSERT_KEY, 32'sd7, 32'sh8000_0000);
    send_req(REQ_INSERT_KEY, 32'sd8, 32'sh7FFF_FFFF);
    send_req(REQ_INSERT_KEY, -32'sd9, 32'sd123);
    send_req(REQ_POP_FRONT, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    // fill to capacity, then hit the full refusal with every insert kind
    for (int i = 0; i < 12; i++)
      send_req((i % 2) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, i * 3 - 20, 32'sd0);
    send_req(REQ_PUSH_FRONT, -32'sd1, 32'sd0);
    send_req(REQ_PUSH_BACK, -32'sd1, 32'sd0);
    send_req(REQ_INSERT_KEY, -32'sd1, 32'sd7);
    send_req(REQ_POP_FRONT, 32'sd0, 32'sd0);

    // random: segments lean hard toward filling, toward draining, or mildly toward filling
    pop_pct = 35;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       pop_pct = 15;
          1:       pop_pct = 60;
          default: pop_pct = 35;
        endcase
        sender_steady = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < pop_pct) kind = REQ_POP_FRONT;
      else kind = req_type_e'($urandom_range(0, 2));
      send_req(kind, pick_value(), pick_value());
    end
    in_valid_i <= 1'b0;

    // let the monitor note the last accepted beat before draining
    @(posedge clk_i);
    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
